>>> rtl/assert_macros.svh
// Assertion macros for the scheduler RTL.
// No dependencies; compiled away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/edf_pkg.sv
// Shared widths, codes, defaults and job entry type of the EDF slot scheduler.
// No dependencies.
package edf_pkg;
    localparam int KIND_W = 2;
    localparam int ID_W   = 6;
    localparam int SLOT_W = 7;
    localparam int WORK_W = 7;
    localparam int ACT_W  = 2;

    localparam int DEF_MAX_JOBS  = 64;
    localparam int DEF_MAX_SLOTS = 128;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [ACT_W-1:0] ACT_IDLE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WORK     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REPORT   = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] deadline;
        logic [WORK_W-1:0] remaining;
    } t_entry;
endpackage

>>> rtl/edf_day_slot_scheduler_top.sv
// EDF slot scheduler: job table in a memory with a registered read port, pending and
// reserved bits in flops. Add beats write the table directly and give no result.
// Tick and finish beats sweep the job table one entry a cycle through its read port;
// no new beat is accepted until their result is registered for output.
// Synchronous active-low reset clears pending, reserved, slot and failure state.
// Depends on edf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module edf_day_slot_scheduler_top #(
    parameter int MAX_JOBS  = edf_pkg::DEF_MAX_JOBS,
    parameter int MAX_SLOTS = edf_pkg::DEF_MAX_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [edf_pkg::KIND_W-1:0] i_kind,
    input  logic [edf_pkg::ID_W-1:0]   i_job_id,
    input  logic [edf_pkg::SLOT_W-1:0] i_deadline_slot,
    input  logic [edf_pkg::WORK_W-1:0] i_work_slots,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [edf_pkg::ACT_W-1:0]  o_action,
    output logic [edf_pkg::ID_W-1:0]   o_served_job,
    output logic [edf_pkg::SLOT_W-1:0] o_slot_number,
    output logic                       o_feasible
);
    import edf_pkg::*;

    localparam int JOB_DEPTH = (MAX_JOBS < (1 << ID_W)) ? MAX_JOBS : (1 << ID_W);
    localparam int RES_DEPTH = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
    localparam int JAW = $clog2(JOB_DEPTH);
    localparam int RAW = $clog2(RES_DEPTH);
    localparam int SW  = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [JOB_DEPTH-1:0] r_pending;
    logic [RES_DEPTH-1:0] r_reserved;
    logic [SW-1:0]        r_slot;
    logic                 r_fail;
    logic                 r_is_tick;

    t_entry               r_mem [JOB_DEPTH];
    t_entry               r_rd_data;
    logic [JAW-1:0]       r_addr;
    logic [JAW-1:0]       r_rd_addr;
    logic                 r_rd_vld;

    logic                 r_found;
    logic [JAW-1:0]       r_best;
    logic [SLOT_W-1:0]    r_best_dl;
    logic [WORK_W-1:0]    r_best_rem;

    logic                 r_out_valid;
    logic [ACT_W-1:0]     r_action;
    logic [ID_W-1:0]      r_served;
    logic [SLOT_W-1:0]    r_slot_out;
    logic                 r_feas_out;

    logic                 w_acc_in;
    logic                 w_add_ok;
    logic                 w_out_free;
    logic                 w_live;
    logic                 w_res_hit;
    logic                 w_work;
    logic                 w_fin_go;
    logic [WORK_W-1:0]    w_new_rem;
    logic                 w_wr_en;
    logic [JAW-1:0]       w_wr_addr;
    t_entry               w_wr_data;
    logic                 w_rd_en;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_acc_in   = i_valid && !o_stall;
    assign w_add_ok   = w_acc_in && (i_kind == KIND_ADD)
                        && (32'(i_job_id) < MAX_JOBS)
                        && (32'(i_deadline_slot) < MAX_SLOTS);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fin_go   = (r_state == ST_FIN) && w_out_free;
    assign w_live     = r_is_tick && (32'(r_slot) < MAX_SLOTS);
    assign w_res_hit  = (32'(r_slot) < RES_DEPTH) && r_reserved[r_slot[RAW-1:0]];
    assign w_work     = w_fin_go && w_live && !w_res_hit && r_found;
    assign w_new_rem  = r_best_rem - WORK_W'(1);
    assign w_rd_en    = (r_state == ST_SCAN);

    always_comb begin
        w_wr_en   = w_add_ok || w_work;
        w_wr_addr = r_best;
        w_wr_data = '{deadline: r_best_dl, remaining: w_new_rem};
        if (w_add_ok) begin
            w_wr_addr = i_job_id[JAW-1:0];
            w_wr_data = '{deadline: i_deadline_slot, remaining: i_work_slots};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in && ((i_kind == KIND_TICK) || (i_kind == KIND_FINISH))) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == JAW'(JOB_DEPTH - 1)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= '0;
            r_reserved  <= '0;
            r_slot      <= '0;
            r_fail      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;

            if (w_add_ok) begin
                if (r_reserved[i_deadline_slot[RAW-1:0]]) begin
                    r_fail <= 1'b1;
                end
                r_reserved[i_deadline_slot[RAW-1:0]] <= 1'b1;
                r_pending[i_job_id[JAW-1:0]]        <= (i_work_slots != '0);
            end

            if ((r_state == ST_IDLE) && (n_state == ST_SCAN)) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (w_rd_en) begin
                r_addr <= r_addr + JAW'(1);
            end

            if (r_rd_vld && r_pending[r_rd_addr]) begin
                if (!r_is_tick) begin
                    r_fail <= 1'b1;
                end else begin
                    if (32'(r_rd_data.deadline) <= 32'(r_slot)) begin
                        r_fail <= 1'b1;
                    end
                    if (!r_found || (r_rd_data.deadline < r_best_dl)) begin
                        r_found <= 1'b1;
                    end
                end
            end

            if (w_fin_go && w_live) begin
                r_slot <= r_slot + SW'(1);
            end
            if (w_work && (w_new_rem == '0)) begin
                r_pending[r_best] <= 1'b0;
            end

            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_is_tick <= (i_kind == KIND_TICK);
        end
        if (w_rd_en) begin
            r_rd_addr <= r_addr;
        end
        if (r_rd_vld && r_pending[r_rd_addr] && r_is_tick
            && (!r_found || (r_rd_data.deadline < r_best_dl))) begin
            r_best     <= r_rd_addr;
            r_best_dl  <= r_rd_data.deadline;
            r_best_rem <= r_rd_data.remaining;
        end
        if (w_fin_go) begin
            r_slot_out <= SLOT_W'(r_slot);
            r_feas_out <= !r_fail;
            r_served   <= w_work ? ID_W'(r_best) : '0;
            if (!r_is_tick) begin
                r_action <= ACT_REPORT;
            end else if (!w_live) begin
                r_action <= ACT_IDLE;
            end else if (w_res_hit) begin
                r_action <= ACT_RESERVED;
            end else if (r_found) begin
                r_action <= ACT_WORK;
            end else begin
                r_action <= ACT_IDLE;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_action      = r_action;
    assign o_served_job  = r_served;
    assign o_slot_number = r_slot_out;
    assign o_feasible    = r_feas_out;

    `ASSERT_NEVER(a_no_write_in_scan, i_clk, i_rst_n, (r_state == ST_SCAN) && w_wr_en)
    `ASSERT_AT(a_result_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
    `ASSERT_AT(a_fail_sticky, i_clk, i_rst_n, r_fail |=> r_fail)
    `ASSERT_AT(a_slot_bound, i_clk, i_rst_n, 32'(r_slot) <= MAX_SLOTS)
    `ASSERT_AT(a_served_in_range, i_clk, i_rst_n,
               (o_valid && (o_action == ACT_WORK)) |-> (32'(o_served_job) < JOB_DEPTH))
endmodule
